[design/utf8_strict_decoder_assert.svh]
// assertion macros for the decoder modules, used by the back end
`ifndef UTF8_STRICT_DECODER_ASSERT_SVH
`define UTF8_STRICT_DECODER_ASSERT_SVH

// checked only outside reset
`define U8SD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define U8SD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[design/utf8sd_pkg.sv]
// types, constants and helpers for the strict utf-8 decoder
package utf8sd_pkg;

  localparam int unsigned CpW     = 21;
  localparam int unsigned FifoAw  = 2;
  localparam int unsigned FifoDepth = 1 << FifoAw;

  typedef enum logic [1:0] {
    KIND_CODE   = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2
  } result_kind_e;

  // one classified byte: an optional code point, then an optional status
  typedef struct packed {
    logic             has_code;
    logic [CpW-1:0]   code_point;
    logic             has_status;
    result_kind_e     status_kind;
  } job_t;

  localparam logic [CpW-1:0] MinLen2   = 21'h00080;
  localparam logic [CpW-1:0] MinLen3   = 21'h00800;
  localparam logic [CpW-1:0] MinLen4   = 21'h10000;
  localparam logic [CpW-1:0] MaxScalar = 21'h10FFFF;
  localparam logic [CpW-1:0] SurLo     = 21'h0D800;
  localparam logic [CpW-1:0] SurHi     = 21'h0DFFF;

  // overlong, range and surrogate check of a completed sequence
  function automatic logic scalar_ok(logic [CpW-1:0] v, logic [2:0] len);
    logic ok;
    ok = 1'b1;
    if (len == 3'd2 && v < MinLen2) ok = 1'b0;
    if (len == 3'd3 && v < MinLen3) ok = 1'b0;
    if (len == 3'd4 && v < MinLen4) ok = 1'b0;
    if (v > MaxScalar) ok = 1'b0;
    if (v >= SurLo && v <= SurHi) ok = 1'b0;
    return ok;
  endfunction

endpackage

[design/utf8sd_front.sv]
// front end: takes bytes, tracks the sequence state, classifies each byte
module utf8sd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        data_byte_i,
  input  logic              message_end_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output utf8sd_pkg::job_t  q_job_o
);
  import utf8sd_pkg::*;

  logic [CpW-1:0] acc_q, acc_d;
  logic [1:0]     rem_q, rem_d;
  logic [2:0]     len_q, len_d;
  logic           failed_q, failed_d;

  logic           accept;
  logic           code_v;
  logic [CpW-1:0] code;
  logic [CpW-1:0] acc_sh;
  logic [1:0]     rem_dec;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign acc_sh     = {acc_q[CpW-7:0], data_byte_i[5:0]};
  assign rem_dec    = rem_q - 2'd1;

  always_comb begin
    acc_d    = acc_q;
    rem_d    = rem_q;
    len_d    = len_q;
    failed_d = failed_q;
    code_v   = 1'b0;
    code     = '0;
    if (!failed_q) begin
      if (rem_q == 2'd0) begin
        if (data_byte_i[7] == 1'b0) begin
          code_v = 1'b1;
          code   = {{(CpW-8){1'b0}}, data_byte_i};
        end else if (data_byte_i[7:5] == 3'b110) begin
          acc_d = {{(CpW-5){1'b0}}, data_byte_i[4:0]};
          rem_d = 2'd1;
          len_d = 3'd2;
        end else if (data_byte_i[7:4] == 4'b1110) begin
          acc_d = {{(CpW-4){1'b0}}, data_byte_i[3:0]};
          rem_d = 2'd2;
          len_d = 3'd3;
        end else if (data_byte_i[7:3] == 5'b11110) begin
          acc_d = {{(CpW-3){1'b0}}, data_byte_i[2:0]};
          rem_d = 2'd3;
          len_d = 3'd4;
        end else begin
          failed_d = 1'b1;
          acc_d    = '0;
          rem_d    = 2'd0;
          len_d    = 3'd0;
        end
      end else if (data_byte_i[7:6] == 2'b10) begin
        acc_d = acc_sh;
        rem_d = rem_dec;
        if (rem_dec == 2'd0) begin
          if (scalar_ok(acc_sh, len_q)) begin
            code_v = 1'b1;
            code   = acc_sh;
            acc_d  = '0;
            len_d  = 3'd0;
          end else begin
            failed_d = 1'b1;
            acc_d    = '0;
            len_d    = 3'd0;
          end
        end
      end else begin
        failed_d = 1'b1;
        acc_d    = '0;
        rem_d    = 2'd0;
        len_d    = 3'd0;
      end
    end

    q_job_o.has_code    = code_v;
    q_job_o.code_point  = code;
    q_job_o.has_status  = message_end_i;
    q_job_o.status_kind = (failed_d || rem_d != 2'd0) ? KIND_REJECT : KIND_ACCEPT;

    // end of message clears everything for the next one
    if (message_end_i) begin
      acc_d    = '0;
      rem_d    = 2'd0;
      len_d    = 3'd0;
      failed_d = 1'b0;
    end
  end

  assign q_push_o = accept && (code_v || message_end_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      rem_q    <= 2'd0;
      len_q    <= 3'd0;
      failed_q <= 1'b0;
    end else if (accept) begin
      acc_q    <= acc_d;
      rem_q    <= rem_d;
      len_q    <= len_d;
      failed_q <= failed_d;
    end
  end

endmodule

[design/utf8sd_fifo.sv]
// short job queue between front and back end
module utf8sd_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  utf8sd_pkg::job_t  push_job_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output utf8sd_pkg::job_t  pop_job_o
);
  import utf8sd_pkg::*;

  job_t              mem_q [FifoDepth];
  logic [FifoAw-1:0] wr_ptr_q, wr_ptr_d;
  logic [FifoAw-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoAw:0]   cnt_q, cnt_d;

  logic do_push, do_pop;

  assign full_o    = (cnt_q == FifoDepth[FifoAw:0]);
  assign empty_o   = (cnt_q == '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign pop_job_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (!do_push && do_pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

[design/utf8sd_back.sv]
// back end: turns queued jobs into result requests, one per cycle unless the output stalls
module utf8sd_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_empty_i,
  input  utf8sd_pkg::job_t          q_job_i,
  output logic                      q_pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                result_kind_o,
  output logic [utf8sd_pkg::CpW-1:0] code_point_o,
  output logic                      run_last_o
);
  import utf8sd_pkg::*;

  logic           vld_q, vld_d;
  result_kind_e   kind_q, kind_d;
  logic [CpW-1:0] cp_q, cp_d;
  logic           last_q, last_d;
  logic           pend_q, pend_d;
  result_kind_e   pend_kind_q, pend_kind_d;

  logic out_free;

  assign out_free = !vld_q || out_ready_i;
  assign q_pop_o  = out_free && !pend_q && !q_empty_i;

  always_comb begin
    vld_d       = vld_q;
    kind_d      = kind_q;
    cp_d        = cp_q;
    last_d      = last_q;
    pend_d      = pend_q;
    pend_kind_d = pend_kind_q;
    if (out_free) begin
      vld_d = 1'b0;
      if (pend_q) begin
        vld_d  = 1'b1;
        kind_d = pend_kind_q;
        cp_d   = '0;
        last_d = 1'b1;
        pend_d = 1'b0;
      end else if (!q_empty_i) begin
        vld_d = 1'b1;
        if (q_job_i.has_code) begin
          kind_d      = KIND_CODE;
          cp_d        = q_job_i.code_point;
          last_d      = !q_job_i.has_status;
          pend_d      = q_job_i.has_status;
          pend_kind_d = q_job_i.status_kind;
        end else begin
          kind_d = q_job_i.status_kind;
          cp_d   = '0;
          last_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= 1'b0;
      kind_q      <= KIND_CODE;
      cp_q        <= '0;
      last_q      <= 1'b0;
      pend_q      <= 1'b0;
      pend_kind_q <= KIND_ACCEPT;
    end else begin
      vld_q       <= vld_d;
      kind_q      <= kind_d;
      cp_q        <= cp_d;
      last_q      <= last_d;
      pend_q      <= pend_d;
      pend_kind_q <= pend_kind_d;
    end
  end

  assign out_valid_o   = vld_q;
  assign result_kind_o = kind_q;
  assign code_point_o  = cp_q;
  assign run_last_o    = last_q;

`include "utf8_strict_decoder_assert.svh"

  `U8SD_ASSERT_ALWAYS(a_pend_has_code, (pend_q |-> (vld_q && kind_q == KIND_CODE)), "status pending without a code point in front")
  `U8SD_ASSERT(a_pend_not_last, ((vld_q && pend_q) |-> !last_q), "code point marked last while a status waits")
  `U8SD_ASSERT(a_status_zero_cp, ((vld_q && kind_q != KIND_CODE) |-> (cp_q == '0 && last_q)), "status request with code point or not last")

endmodule

[design/utf8_strict_decoder.sv]
// strict validating utf-8 decoder, top level
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+------------------------------------
//  in       | input     | in_valid_i / in_ready_o | data_byte_i, message_end_i
//  out      | output    | out_valid_o/out_ready_i | result_kind_o, code_point_o, run_last_o
//
// one byte is taken per cycle while the queue has room; the front end decodes it in that
// cycle and queues its results, so a code point passes a queue entry and then the output
// register; the output register sends one request per cycle while out_ready_i is high
// a byte that ends both a sequence and the message yields two requests, code point first
// reset clears the sequence state, the four-entry queue and the output register
// a stalled output fills the queue, and only then is in_ready_o dropped
module utf8_strict_decoder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  data_byte_i,
  input  logic                        message_end_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  result_kind_o,
  output logic [utf8sd_pkg::CpW-1:0]  code_point_o,
  output logic                        run_last_o
);
  import utf8sd_pkg::*;

  // queue side of the front end
  logic q_push;
  job_t q_push_job;
  logic q_full;

  // queue side of the back end
  logic q_pop;
  logic q_empty;
  job_t q_pop_job;

  // byte classification and sequence tracking
  utf8sd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .message_end_i (message_end_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_job_o       (q_push_job)
  );

  // decouples decode from output backpressure
  utf8sd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_job_i (q_push_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .pop_job_o  (q_pop_job)
  );

  // splits each job into code point and status requests
  utf8sd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_job_i       (q_pop_job),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_o (result_kind_o),
    .code_point_o  (code_point_o),
    .run_last_o    (run_last_o)
  );

endmodule

[verif/utf8_strict_decoder_tb.sv]
// self-checking testbench for the strict utf-8 decoder: byte driver, result monitor and scoreboard
`timescale 1ns / 1ps

module utf8_strict_decoder_tb;
  import utf8sd_pkg::*;

  // run limit in clock cycles, several times the slowest legal run
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ByteTarget = 1550;
  localparam int unsigned DrainCycles = 20;

  // scalar values on the borders of the length classes and the surrogate hole
  localparam logic [CpW-1:0] Corner [9] = '{
    21'h00007F, 21'h000080, 21'h0007FF, 21'h000800, 21'h00D7FF,
    21'h00E000, 21'h00FFFF, 21'h010000, 21'h10FFFF
  };

  // one byte request as the driver presents it
  typedef struct {
    logic [7:0] data;
    logic       msg_end;
  } msg_byte_t;

  // one decoder result as the monitor should see it
  typedef struct {
    result_kind_e   kind;
    logic [CpW-1:0] cp;
    logic           run_end;
  } decoded_t;

  logic           clk_i = 1'b0;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_ready_o;
  logic [7:0]     data_byte_i;
  logic           message_end_i;
  logic           out_valid_o;
  logic           out_ready_i;
  logic [1:0]     result_kind_o;
  logic [CpW-1:0] code_point_o;
  logic           run_last_o;

  utf8_strict_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .message_end_i (message_end_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_o (result_kind_o),
    .code_point_o  (code_point_o),
    .run_last_o    (run_last_o)
  );

  // 12 ns period
  always #6 clk_i = ~clk_i;

  // byte stream still to be driven, and results still owed by the decoder
  msg_byte_t byte_feed [$];
  msg_byte_t msg_buf [$];
  decoded_t  awaited_results [$];

  // decoder state as the scoreboard tracks it
  logic [CpW-1:0] acc_value;
  logic [1:0]     cont_left;
  logic [2:0]     seq_len;
  logic           msg_bad;

  int unsigned live_bytes;
  int unsigned msg_count;
  int unsigned total_bytes;
  int unsigned bytes_taken;
  int unsigned in_stalls;
  int unsigned fail_count;
  int unsigned codes_seen;
  int unsigned accepts_seen;
  int unsigned rejects_seen;
  int unsigned cycle_count;

  logic        byte_taken;
  logic        hold_off;
  int unsigned gap_left;
  int unsigned items_sent;
  bit          feed_calm;
  msg_byte_t   drv_item;
  int unsigned stall_left;
  int unsigned sink_cycle;
  bit          sink_calm;
  int unsigned sink_roll;

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------

  task automatic put(input logic [7:0] b);
    msg_byte_t mb;
    mb.data = b;
    mb.msg_end = 1'b0;
    msg_buf.insert(msg_buf.size(), mb);
  endtask

  // encode v in exactly len bytes; a len above the natural one gives an overlong form
  task automatic put_seq(input logic [CpW-1:0] v, input int unsigned len);
    case (len)
      1: put({1'b0, v[6:0]});
      2: begin
        put({3'b110, v[10:6]});
        put({2'b10, v[5:0]});
      end
      3: begin
        put({4'b1110, v[15:12]});
        put({2'b10, v[11:6]});
        put({2'b10, v[5:0]});
      end
      default: begin
        put({5'b11110, v[20:18]});
        put({2'b10, v[17:12]});
        put({2'b10, v[11:6]});
        put({2'b10, v[5:0]});
      end
    endcase
  endtask

  // flag the final byte and hand the message to the driver
  task automatic flush_msg();
    msg_buf[msg_buf.size() - 1].msg_end = 1'b1;
    byte_feed = {byte_feed, msg_buf};
    msg_buf.delete();
    msg_count++;
  endtask

  // legal scalar whose shortest encoding is len bytes
  function automatic logic [CpW-1:0] pick_scalar(input int unsigned len);
    logic [CpW-1:0] v;
    case (len)
      1: v = CpW'($urandom_range(0, 'h7F));
      2: v = CpW'($urandom_range('h80, 'h7FF));
      3: begin
        // skip over the surrogate hole
        v = CpW'($urandom_range('h800, 'hF7FF));
        if (v >= SurLo) v = v + 21'h000800;
      end
      default: v = CpW'($urandom_range('h10000, 'h10FFFF));
    endcase
    return v;
  endfunction

  // one random message: mostly clean text, some with a fault somewhere inside
  task automatic gen_message();
    int unsigned n_chars, fault_at, sel, len, drop;
    logic [CpW-1:0] v;
    n_chars = $urandom_range(1, 10);
    fault_at = ($urandom_range(0, 99) < 25) ? $urandom_range(0, n_chars - 1) : n_chars;
    for (int k = 0; k < fault_at; k++) begin
      sel = $urandom_range(0, 9);
      if (sel == 9) begin
        v = Corner[4'($urandom_range(0, 8))];
        len = (v < MinLen2) ? 1 : (v < MinLen3) ? 2 : (v < MinLen4) ? 3 : 4;
      end else begin
        len = (sel < 4) ? 1 : (sel < 6) ? 2 : (sel < 8) ? 3 : 4;
        v = pick_scalar(len);
      end
      put_seq(v, len);
    end
    if (fault_at == n_chars) begin
      live_bytes += msg_buf.size();
      flush_msg();
    end else begin
      sel = $urandom_range(0, 7);
      len = $urandom_range(2, 4);
      case (sel)
        // overlong form
        0: put_seq(CpW'($urandom_range(0, (len == 2) ? 'h7F : (len == 3) ? 'h7FF : 'hFFFF)),
                   len);
        // surrogate
        1: put_seq(CpW'($urandom_range(SurLo, SurHi)), 3);
        // beyond the last scalar, leads f4..f7
        2: put_seq(CpW'($urandom_range(MaxScalar + 1, 'h1FFFFF)), 4);
        // stray continuation in lead position
        3: put(8'($urandom_range('h80, 'hBF)));
        // lead byte f8..ff
        4: put(8'($urandom_range('hF8, 'hFF)));
        // non-continuation byte inside a sequence
        5: begin
          put_seq(pick_scalar(len), len);
          drop = $urandom_range(1, len - 1);
          repeat (drop) void'(msg_buf.pop_back());
          put(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 'h7F))
                                          : 8'($urandom_range('hC0, 'hFF)));
        end
        // sequence cut off by the end of the message
        6: begin
          put_seq(pick_scalar(len), len);
          drop = $urandom_range(1, len - 1);
          repeat (drop) void'(msg_buf.pop_back());
        end
        // raw noise
        default: repeat ($urandom_range(1, 6)) put(8'($urandom_range(0, 255)));
      endcase
      live_bytes += msg_buf.size();
      // trailing bytes after an error are ignored by the decoder, cut-off ends right here
      if (sel != 6) repeat ($urandom_range(0, 3)) put(8'($urandom_range(0, 255)));
      flush_msg();
    end
  endtask

  // ---------------------------------------------------------------------------
  // scoreboard prediction
  // ---------------------------------------------------------------------------

  task automatic bad_msg();
    msg_bad = 1'b1;
    acc_value = '0;
    cont_left = '0;
    seq_len = '0;
  endtask

  // expected results of one accepted byte, appended to awaited_results
  task automatic decode_byte(input logic [7:0] b, input logic fin);
    decoded_t       res [$];
    logic [CpW-1:0] floor_v;
    if (!msg_bad) begin
      if (cont_left == 2'd0) begin
        if (!b[7]) begin
          res.insert(res.size(), '{kind: KIND_CODE, cp: {13'd0, b}, run_end: 1'b0});
        end else if (b[7:5] == 3'b110) begin
          acc_value = {16'd0, b[4:0]};
          cont_left = 2'd1;
          seq_len = 3'd2;
        end else if (b[7:4] == 4'b1110) begin
          acc_value = {17'd0, b[3:0]};
          cont_left = 2'd2;
          seq_len = 3'd3;
        end else if (b[7:3] == 5'b11110) begin
          acc_value = {18'd0, b[2:0]};
          cont_left = 2'd3;
          seq_len = 3'd4;
        end else begin
          // stray continuation or f8..ff as lead
          bad_msg();
        end
      end else if (b[7:6] == 2'b10) begin
        acc_value = {acc_value[14:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left == 2'd0) begin
          // shortest-form floor of this sequence length
          case (seq_len)
            3'd2:    floor_v = MinLen2;
            3'd3:    floor_v = MinLen3;
            3'd4:    floor_v = MinLen4;
            default: floor_v = '0;
          endcase
          if (acc_value >= floor_v && acc_value <= MaxScalar &&
              !(acc_value >= SurLo && acc_value <= SurHi)) begin
            res.insert(res.size(), '{kind: KIND_CODE, cp: acc_value, run_end: 1'b0});
            acc_value = '0;
            seq_len = '0;
          end else begin
            bad_msg();
          end
        end
      end else begin
        // no reinterpretation as a new lead
        bad_msg();
      end
    end
    if (fin) begin
      if (msg_bad || cont_left != 2'd0) begin
        res.insert(res.size(), '{kind: KIND_REJECT, cp: '0, run_end: 1'b0});
      end else begin
        res.insert(res.size(), '{kind: KIND_ACCEPT, cp: '0, run_end: 1'b0});
      end
      acc_value = '0;
      cont_left = '0;
      seq_len = '0;
      msg_bad = 1'b0;
    end
    if (res.size() != 0) res[res.size() - 1].run_end = 1'b1;
    awaited_results = {awaited_results, res};
  endtask

  // ---------------------------------------------------------------------------
  // input side: acceptance at the rising edge, new requests at the falling edge
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    byte_taken <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i) begin
      if (in_ready_o) begin
        decode_byte(data_byte_i, message_end_i);
        bytes_taken++;
      end else begin
        in_stalls++;
      end
    end
  end

  // random gaps, most short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || byte_taken)) begin
      if (gap_left != 0) begin
        in_valid_i <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (byte_feed.size() != 0) begin
        drv_item = byte_feed.pop_front();
        in_valid_i <= 1'b1;
        data_byte_i <= drv_item.data;
        message_end_i <= drv_item.msg_end;
        // every hundred requests, maybe switch to a stretch without gaps
        if (items_sent % 100 == 0) feed_calm = ($urandom_range(0, 3) == 0);
        items_sent++;
        gap_left <= feed_calm ? 0 : pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output side: ready pattern at the falling edge, check at the rising edge
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (rst_ni) begin
      sink_cycle++;
      if (sink_cycle % 150 == 0) sink_calm = ($urandom_range(0, 2) == 0);
      if (hold_off) begin
        out_ready_i <= 1'b0;
      end else if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (sink_calm) begin
        out_ready_i <= 1'b1;
      end else begin
        sink_roll = $urandom_range(0, 99);
        if (sink_roll < 4) begin
          stall_left = $urandom_range(8, 40);
          out_ready_i <= 1'b0;
        end else begin
          out_ready_i <= (sink_roll < 70);
        end
      end
    end
  end

  // one long back-pressure stretch while the driver keeps offering bytes,
  // enough to fill the result queue and drop in_ready_o
  initial begin
    hold_off = 1'b0;
    while (bytes_taken < 400) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      case (result_kind_o)
        KIND_CODE:   codes_seen++;
        KIND_ACCEPT: accepts_seen++;
        default:     rejects_seen++;
      endcase
      if (awaited_results.size() == 0) begin
        $error("unexpected result: result_kind %0d code_point %h run_last %0d",
               result_kind_o, code_point_o, run_last_o);
        fail_count++;
      end else begin
        automatic decoded_t want = awaited_results.pop_front();
        if (result_kind_o !== want.kind) begin
          $error("result_kind: expected %0d, got %0d", want.kind, result_kind_o);
          fail_count++;
        end
        if (code_point_o !== want.cp) begin
          $error("code_point: expected %h, got %h", want.cp, code_point_o);
          fail_count++;
        end
        if (run_last_o !== want.run_end) begin
          $error("run_last: expected %0d, got %0d", want.run_end, run_last_o);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $error("timeout after %0d cycles, %0d of %0d bytes taken, %0d results owed",
             CycleLimit, bytes_taken, total_bytes, awaited_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    data_byte_i = '0;
    message_end_i = 1'b0;
    out_ready_i = 1'b0;
    byte_taken = 1'b0;
    acc_value = '0;
    cont_left = '0;
    seq_len = '0;
    msg_bad = 1'b0;
    live_bytes = 0;
    msg_count = 0;
    bytes_taken = 0;
    in_stalls = 0;
    fail_count = 0;
    codes_seen = 0;
    accepts_seen = 0;
    rejects_seen = 0;
    cycle_count = 0;
    gap_left = 0;
    items_sent = 0;
    feed_calm = 1'b0;
    stall_left = 0;
    sink_cycle = 0;
    sink_calm = 1'b0;

    // directed: smallest scalar of the one-, two- and three-byte classes, then the
    // largest scalar, ending on a byte that yields both a code point and the status
    put_seq(21'h000000, 1);
    put_seq(21'h000080, 2);
    put_seq(21'h000800, 3);
    put_seq(MaxScalar, 4);
    flush_msg();
    // single ascii byte message
    put_seq(21'h00007F, 1);
    flush_msg();
    // overlong c0 80, then ignored bytes after the error
    put_seq(21'h000000, 2);
    put(8'hFF);
    put(8'h41);
    flush_msg();
    // surrogate, error on the final byte itself
    put_seq(SurLo, 3);
    flush_msg();
    // above the last scalar
    put_seq(MaxScalar + 1, 4);
    flush_msg();
    // stray continuation in lead position
    put(8'h80);
    flush_msg();
    // illegal lead byte
    put(8'hF8);
    flush_msg();
    // ascii where a continuation should be
    put(8'hE2);
    put(8'h41);
    flush_msg();
    // sequence cut off by the end of the message
    put(8'hF0);
    put(8'h90);
    flush_msg();
    live_bytes = byte_feed.size();

    while (live_bytes < ByteTarget) gen_message();
    total_bytes = byte_feed.size();

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (bytes_taken < total_bytes) @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
    // catch anything extra the decoder still sends
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d bytes in %0d messages: %0d code points, %0d accepted, %0d rejected",
             total_bytes, msg_count, codes_seen, accepts_seen, rejects_seen);
    $display("input held off by output back-pressure on %0d cycles", in_stalls);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
